>>> hw/rtl/tvsd_pkg.sv
package tvsd_pkg;

    localparam int POINTER_BYTES_DEF = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        PH_TAG  = 3'd0,
        PH_NUM  = 3'd1,
        PH_ESC  = 3'd2,
        PH_STR  = 3'd3,
        PH_SKIP = 3'd4
    } phase_t;

    typedef enum logic [3:0] {
        K_NIL    = 4'd0,
        K_BOOL   = 4'd1,
        K_INT    = 4'd2,
        K_REAL   = 4'd3,
        K_PTR    = 4'd4,
        K_SSTART = 4'd5,
        K_SBYTE  = 4'd6,
        K_ARRAY  = 4'd7,
        K_END    = 4'd8,
        K_ERR    = 4'd9
    } item_kind_t;

    typedef enum logic [1:0] {
        IT_INT  = 2'd0,
        IT_REAL = 2'd1,
        IT_PTR  = 2'd2,
        IT_SLEN = 2'd3
    } item_type_t;

    localparam logic [2:0] TAG_NIL   = 3'd0;
    localparam logic [2:0] TAG_BOOL  = 3'd1;
    localparam logic [2:0] TAG_NUM   = 3'd2;
    localparam logic [2:0] TAG_PTR   = 3'd3;
    localparam logic [2:0] TAG_SSTR  = 3'd4;
    localparam logic [2:0] TAG_LSTR  = 3'd5;
    localparam logic [2:0] TAG_ARRAY = 3'd6;
    localparam logic [4:0] COOKIE_ESCAPE = 5'd31;
    localparam logic [4:0] COOKIE_REAL   = 5'd8;
    localparam logic [4:0] COOKIE_I64    = 5'd6;

    // one result item
    typedef struct packed {
        logic        last_of_string;
        logic [7:0]  data_byte;
        logic [63:0] item_value;
        item_kind_t  item_kind;
    } result_t;

    // one input item: a byte and its end-of-buffer flag
    typedef struct packed {
        logic       is_end;
        logic [7:0] byte_in;
    } entry_t;

endpackage

>>> hw/rtl/tvsd_front.sv
module tvsd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tvsd_pkg::entry_t   in_entry,
    output logic               q_valid,
    input  logic               q_ready,
    output tvsd_pkg::entry_t   q_entry
);

    localparam int DEPTH = tvsd_pkg::QUEUE_DEPTH;

    tvsd_pkg::entry_t mem_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready = (count_reg != 2'(DEPTH));
    assign q_valid  = (count_reg != 2'd0);
    assign q_entry  = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(DEPTH)) else $error("queue overfilled");
    a_empty_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> !pop) else $error("pop from empty queue");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("count lost a push");

endmodule

>>> hw/rtl/tvsd_back.sv
module tvsd_back #(
    parameter int POINTER_BYTES = tvsd_pkg::POINTER_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  tvsd_pkg::entry_t   q_entry,
    output logic               out_valid,
    input  logic               out_ready,
    output tvsd_pkg::result_t  out_result
);

    tvsd_pkg::phase_t     phase_reg, phase_next;
    tvsd_pkg::item_type_t itype_reg, itype_next;
    logic [4:0]  cookie_reg, cookie_next;
    logic [3:0]  want_reg, want_next;
    logic [3:0]  seen_reg, seen_next;
    logic [63:0] asm_reg, asm_next;
    logic [31:0] sremain_reg, sremain_next;
    logic        esc_reg, esc_next;
    logic        ovalid_reg;
    tvsd_pkg::result_t ores_reg;

    logic        emit;
    tvsd_pkg::result_t res;
    logic        take;
    logic [2:0]  ttype;
    logic [4:0]  tck;
    logic [63:0] v;
    logic [7:0]  b;

    assign q_ready    = !ovalid_reg || out_ready;
    assign take       = q_valid && q_ready;
    assign out_valid  = ovalid_reg;
    assign out_result = ores_reg;
    assign b          = q_entry.byte_in;

    always_comb
    begin
        phase_next   = phase_reg;
        itype_next   = itype_reg;
        cookie_next  = cookie_reg;
        want_next    = want_reg;
        seen_next    = seen_reg;
        asm_next     = asm_reg;
        sremain_next = sremain_reg;
        esc_next     = esc_reg;
        emit         = 1'b0;
        res          = '0;
        res.item_kind = tvsd_pkg::K_NIL;
        ttype        = b[2:0];
        tck          = b[7:3];
        v            = asm_reg;
        if (q_entry.is_end)
        begin
            phase_next   = tvsd_pkg::PH_TAG;
            itype_next   = tvsd_pkg::IT_INT;
            cookie_next  = '0;
            want_next    = '0;
            seen_next    = '0;
            asm_next     = '0;
            sremain_next = '0;
            esc_next     = 1'b0;
            emit         = (phase_reg != tvsd_pkg::PH_SKIP);
            res.item_kind = (phase_reg == tvsd_pkg::PH_TAG) ? tvsd_pkg::K_END
                                                            : tvsd_pkg::K_ERR;
        end
        else
        begin
            // escape phase reuses the integer-cookie path of a number tag
            if (phase_reg == tvsd_pkg::PH_ESC)
            begin
                if (ttype != tvsd_pkg::TAG_NUM || tck == tvsd_pkg::COOKIE_REAL)
                begin
                    ttype = tvsd_pkg::TAG_NIL;
                    tck   = tvsd_pkg::COOKIE_ESCAPE;
                end
            end
            case (phase_reg)
                tvsd_pkg::PH_TAG, tvsd_pkg::PH_ESC:
                begin
                    if (phase_reg == tvsd_pkg::PH_ESC && tck == tvsd_pkg::COOKIE_ESCAPE)
                    begin
                        emit = 1'b1;
                        res.item_kind = tvsd_pkg::K_ERR;
                        phase_next = tvsd_pkg::PH_SKIP;
                        esc_next = 1'b0;
                    end
                    else
                    begin
                        case (ttype)
                            tvsd_pkg::TAG_NIL:
                            begin
                                emit = 1'b1;
                                res.item_kind = tvsd_pkg::K_NIL;
                            end
                            tvsd_pkg::TAG_BOOL:
                            begin
                                emit = 1'b1;
                                res.item_kind = tvsd_pkg::K_BOOL;
                                res.item_value = {63'd0, tck != 5'd0};
                            end
                            tvsd_pkg::TAG_NUM:
                            begin
                                if (tck == tvsd_pkg::COOKIE_REAL)
                                begin
                                    phase_next = tvsd_pkg::PH_NUM;
                                    itype_next = tvsd_pkg::IT_REAL;
                                    cookie_next = tck;
                                    want_next = 4'd8;
                                    seen_next = '0;
                                    asm_next = '0;
                                end
                                else if (tck == 5'd0)
                                begin
                                    emit = 1'b1;
                                    res.item_kind = esc_reg ? tvsd_pkg::K_ARRAY
                                                            : tvsd_pkg::K_INT;
                                    esc_next = 1'b0;
                                    phase_next = tvsd_pkg::PH_TAG;
                                end
                                else if (tck inside {5'd1, 5'd2, 5'd4, tvsd_pkg::COOKIE_I64})
                                begin
                                    phase_next = tvsd_pkg::PH_NUM;
                                    itype_next = tvsd_pkg::IT_INT;
                                    cookie_next = tck;
                                    want_next = (tck == tvsd_pkg::COOKIE_I64) ? 4'd8
                                                                              : tck[3:0];
                                    seen_next = '0;
                                    asm_next = '0;
                                end
                                else
                                begin
                                    emit = 1'b1;
                                    res.item_kind = tvsd_pkg::K_ERR;
                                    phase_next = tvsd_pkg::PH_SKIP;
                                    esc_next = 1'b0;
                                end
                            end
                            tvsd_pkg::TAG_PTR:
                            begin
                                phase_next = tvsd_pkg::PH_NUM;
                                itype_next = tvsd_pkg::IT_PTR;
                                cookie_next = '0;
                                want_next = 4'(POINTER_BYTES);
                                seen_next = '0;
                                asm_next = '0;
                            end
                            tvsd_pkg::TAG_SSTR:
                            begin
                                emit = 1'b1;
                                res.item_kind = tvsd_pkg::K_SSTART;
                                res.item_value = {59'd0, tck};
                                sremain_next = {27'd0, tck};
                                phase_next = (tck != 5'd0) ? tvsd_pkg::PH_STR
                                                           : tvsd_pkg::PH_TAG;
                            end
                            tvsd_pkg::TAG_LSTR:
                            begin
                                if (tck == 5'd2 || tck == 5'd4)
                                begin
                                    phase_next = tvsd_pkg::PH_NUM;
                                    itype_next = tvsd_pkg::IT_SLEN;
                                    cookie_next = tck;
                                    want_next = tck[3:0];
                                    seen_next = '0;
                                    asm_next = '0;
                                end
                                else
                                begin
                                    emit = 1'b1;
                                    res.item_kind = tvsd_pkg::K_ERR;
                                    phase_next = tvsd_pkg::PH_SKIP;
                                    esc_next = 1'b0;
                                end
                            end
                            tvsd_pkg::TAG_ARRAY:
                            begin
                                if (tck != tvsd_pkg::COOKIE_ESCAPE)
                                begin
                                    emit = 1'b1;
                                    res.item_kind = tvsd_pkg::K_ARRAY;
                                    res.item_value = {59'd0, tck};
                                end
                                else
                                begin
                                    esc_next = 1'b1;
                                    phase_next = tvsd_pkg::PH_ESC;
                                end
                            end
                            default:
                            begin
                                emit = 1'b1;
                                res.item_kind = tvsd_pkg::K_ERR;
                                phase_next = tvsd_pkg::PH_SKIP;
                                esc_next = 1'b0;
                            end
                        endcase
                    end
                end
                tvsd_pkg::PH_NUM:
                begin
                    if (seen_reg < 4'd8)
                    begin
                        v = asm_reg | ({56'd0, b} << {seen_reg[2:0], 3'b000});
                    end
                    asm_next  = v;
                    seen_next = seen_reg + 4'd1;
                    if (seen_next >= want_reg)
                    begin
                        phase_next = tvsd_pkg::PH_TAG;
                        emit = 1'b1;
                        case (itype_reg)
                            tvsd_pkg::IT_REAL:
                            begin
                                res.item_kind = tvsd_pkg::K_REAL;
                                res.item_value = v;
                            end
                            tvsd_pkg::IT_PTR:
                            begin
                                res.item_kind = tvsd_pkg::K_PTR;
                                res.item_value = v;
                            end
                            tvsd_pkg::IT_SLEN:
                            begin
                                res.item_kind = tvsd_pkg::K_SSTART;
                                res.item_value = {32'd0, v[31:0]};
                                sremain_next = v[31:0];
                                phase_next = (v[31:0] != 32'd0) ? tvsd_pkg::PH_STR
                                                                 : tvsd_pkg::PH_TAG;
                            end
                            default:
                            begin
                                if (cookie_reg == 5'd4 && v[31])
                                begin
                                    v[63:32] = '1;
                                end
                                res.item_value = v;
                                res.item_kind = tvsd_pkg::K_INT;
                                if (esc_reg)
                                begin
                                    esc_next = 1'b0;
                                    if (v[63:32] != 32'd0)
                                    begin
                                        res.item_kind = tvsd_pkg::K_ERR;
                                        res.item_value = '0;
                                        phase_next = tvsd_pkg::PH_SKIP;
                                    end
                                    else
                                    begin
                                        res.item_kind = tvsd_pkg::K_ARRAY;
                                    end
                                end
                            end
                        endcase
                    end
                end
                tvsd_pkg::PH_STR:
                begin
                    emit = 1'b1;
                    res.item_kind = tvsd_pkg::K_SBYTE;
                    res.data_byte = b;
                    res.last_of_string = (sremain_reg <= 32'd1);
                    sremain_next = sremain_reg - 32'd1;
                    if (sremain_reg <= 32'd1)
                    begin
                        phase_next = tvsd_pkg::PH_TAG;
                    end
                end
                default:
                begin
                    phase_next = tvsd_pkg::PH_SKIP;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            ores_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= tvsd_pkg::PH_TAG;
            itype_reg   <= tvsd_pkg::IT_INT;
            cookie_reg  <= '0;
            want_reg    <= '0;
            seen_reg    <= '0;
            asm_reg     <= '0;
            sremain_reg <= '0;
            esc_reg     <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg   <= phase_next;
                itype_reg   <= itype_next;
                cookie_reg  <= cookie_next;
                want_reg    <= want_next;
                seen_reg    <= seen_next;
                asm_reg     <= asm_next;
                sremain_reg <= sremain_next;
                esc_reg     <= esc_next;
            end
            if (take)
            begin
                ovalid_reg <= emit;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !out_ready) |=> ovalid_reg && $stable(ores_reg))
        else $error("result dropped under stall");
    a_esc_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tvsd_pkg::PH_ESC) |-> esc_reg)
        else $error("escape phase without pending flag");
    a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (take && phase_reg == tvsd_pkg::PH_SKIP && !q_entry.is_end) |-> !emit)
        else $error("result produced while skipping");

endmodule

>>> hw/rtl/tagged_value_stream_decoder.sv
// channel | dir | tdata (low bit up)                         | tuser          | tlast
// s_axis  | in  | byte_in[7:0]                               | kind           | -
// m_axis  | out | item_value[63:0], data_byte[71:64]         | item_kind[3:0] | last_of_string
//
// one item a cycle sustained unless output stalls; queue, then result register
// the parser register set updates once per accepted item, a single shift-in step
// asynchronous active-low reset returns the parser to expecting a tag byte
// input and output stall independently through a two-entry queue
module tagged_value_stream_decoder #(
    parameter int POINTER_BYTES = tvsd_pkg::POINTER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_in
    input  logic        s_axis_tuser,   // kind: 1 = end of buffer
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // item_value, data_byte
    output logic [3:0]  m_axis_tuser,   // item_kind
    output logic        m_axis_tlast    // last_of_string
);

    tvsd_pkg::entry_t  in_entry, q_entry;
    tvsd_pkg::result_t res;
    logic              q_valid, q_ready;

    assign in_entry.is_end  = s_axis_tuser;
    assign in_entry.byte_in = s_axis_tdata;

    // front: accepts items into the queue
    tvsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_entry (in_entry),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_entry  (q_entry)
    );

    // back: parser and result register
    tvsd_back #(
        .POINTER_BYTES (POINTER_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_entry    (q_entry),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (res)
    );

    assign m_axis_tdata = {res.data_byte, res.item_value};
    assign m_axis_tuser = res.item_kind;
    assign m_axis_tlast = res.last_of_string;

endmodule
